// ===== rtl/itrd_pkg.sv =====
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers of the integer to radix digits block.
// ----------------------------------------------------------------------------
package itrd_pkg;

  localparam int MAG_W          = 64;  // widest magnitude handled
  localparam int DIV_BITS       = 8;   // dividend bits consumed per divider cycle
  localparam int MAX_DIGITS_DEF = 64;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 8;
  localparam int RADIX_W        = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  // Opcodes
  localparam logic [1:0] OP_S32 = 2'd0;
  localparam logic [1:0] OP_U32 = 2'd1;
  localparam logic [1:0] OP_U64 = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd2;

  // Reset values: radix 10, table "0123456789abcdef"
  localparam logic [RADIX_W-1:0]    RADIX_RST      = 5'd10;
  localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RST = 64'h6665_6463_6261_3938;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } itrd_job_t;

  typedef struct packed {
    logic [RADIX_W-1:0]    radix;
    logic [CFG_DATA_W-1:0] chars_low;
    logic [CFG_DATA_W-1:0] chars_high;
  } itrd_cfg_t;

  // Clamp the radix register into the supported range.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < MIN_RADIX) res = MIN_RADIX;
    if (r > MAX_RADIX) res = MAX_RADIX;
    return res;
  endfunction

  // Look up the character of one digit value.
  function automatic logic [CHAR_W-1:0] digit_char(input itrd_cfg_t cfg,
                                                   input logic [DIGIT_W-1:0] d);
    logic [2*CFG_DATA_W-1:0] tbl;
    tbl = {cfg.chars_high, cfg.chars_low};
    return tbl[{d, 3'b000} +: CHAR_W];
  endfunction

endpackage

// ===== rtl/itrd_ram.sv =====
// ----------------------------------------------------------------------------
// itrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itrd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/itrd_front.sv =====
// ----------------------------------------------------------------------------
// itrd_front
// Accepts numbers, resolves sign and magnitude, queues jobs in a 2-entry FIFO.
// ----------------------------------------------------------------------------
module itrd_front
  import itrd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [MAG_W-1:0]      number_value_i,
  input  logic [1:0]            opcode_i,
  output logic                  job_valid_o,
  output itrd_job_t             job_o,
  input  logic                  job_pop_i
);

  itrd_job_t   entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q;
  itrd_job_t   job_new;
  logic [31:0] v32;
  logic        push;

  // Classify by opcode; unused opcode behaves as unsigned 64-bit.
  always_comb begin
    v32         = number_value_i[31:0];
    job_new.neg = 1'b0;
    job_new.mag = number_value_i;
    case (opcode_i)
      OP_S32: begin
        job_new.neg = v32[31];
        job_new.mag = {32'b0, (v32[31] ? (~v32 + 32'd1) : v32)};
      end
      OP_U32: begin
        job_new.mag = {32'b0, v32};
      end
      default: begin
        job_new.mag = number_value_i;
      end
    endcase
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (fill_q != 2'd0);
  assign job_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (job_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + {1'b0, push} - {1'b0, job_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

// ===== rtl/itrd_back.sv =====
// ----------------------------------------------------------------------------
// itrd_back
// Divides a job into digits onto a stack RAM, then emits sign and digits.
// ----------------------------------------------------------------------------
module itrd_back
  import itrd_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itrd_cfg_t         cfg_i,
  input  logic              job_valid_i,
  input  itrd_job_t         job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              last_char_o
);

  localparam int IdxW   = $clog2(MAX_DIGITS);
  localparam int CntW   = $clog2(MAX_DIGITS + 1);
  localparam int PhaseW = $clog2(MAG_W / DIV_BITS);
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(MAG_W / DIV_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_WAIT
  } state_e;

  state_e             state_q;
  logic [MAG_W-1:0]   mag_q;
  logic [DIGIT_W-1:0] rem_q;
  logic               neg_q;
  logic [PhaseW-1:0]  phase_q;
  logic [CntW-1:0]    count_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_last_q;

  logic [RADIX_W-1:0] radix_eff;
  logic [MAG_W-1:0]   div_mag;
  logic [DIGIT_W-1:0] div_rem;
  logic [CntW-1:0]    count_dec;
  logic [DIGIT_W-1:0] rd_digit;
  logic               out_free;
  logic               out_load;
  logic               ram_we;
  logic               ram_re;

  assign radix_eff = eff_radix(cfg_i.radix);

  // Restoring long division, DIV_BITS dividend bits per cycle; quotient
  // bits shift into the bottom of the magnitude register.
  always_comb begin
    logic [MAG_W-1:0]   m;
    logic [DIGIT_W-1:0] rm;
    logic [DIGIT_W:0]   t;
    m  = mag_q;
    rm = rem_q;
    t  = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {rm, m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
      if (t >= radix_eff) begin
        m[0] = 1'b1;
        rm   = DIGIT_W'(t - radix_eff);
      end else begin
        rm   = t[DIGIT_W-1:0];
      end
    end
    div_mag = m;
    div_rem = rm;
  end

  assign count_dec = count_q - CntW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = out_free && ((state_q == ST_SIGN) || (state_q == ST_WAIT));
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign ram_we    = (state_q == ST_DIV) && (phase_q == PhaseLast);
  assign ram_re    = (state_q == ST_READ);

  itrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (count_dec[IdxW-1:0]),
    .rdata_o (rd_digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      phase_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            mag_q   <= job_i.mag;
            neg_q   <= job_i.neg;
            rem_q   <= '0;
            phase_q <= '0;
            count_q <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          mag_q   <= div_mag;
          phase_q <= phase_q + PhaseW'(1);
          if (phase_q == PhaseLast) begin
            rem_q   <= '0;
            count_q <= count_q + CntW'(1);
            // Stop on a zero quotient or a full stack.
            if ((div_mag == '0) || (count_q == CntW'(MAX_DIGITS - 1))) begin
              state_q <= neg_q ? ST_SIGN : ST_READ;
            end
          end else begin
            rem_q <= div_rem;
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_char_q  <= MINUS_CHAR;
            out_last_q  <= 1'b0;
            state_q     <= ST_READ;
          end
        end
        ST_READ: begin
          count_q <= count_dec;
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_free) begin
            out_char_q  <= digit_char(cfg_i, rd_digit);
            out_last_q  <= (count_q == '0);
            state_q     <= (count_q == '0) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = out_last_q;

endmodule

// ===== rtl/integer_to_radix_digits_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts integers to character strings in a configurable radix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one number and an opcode per
//   transaction: signed 32-bit, unsigned 32-bit or unsigned 64-bit.
//   Output channel (out_valid_o / out_stall_i): one character per
//   transaction, most significant digit first, a leading '-' for signed
//   negatives; last_char_o marks the final character of each number.
//   Configuration port: write radix (index 0) and the two halves of the
//   16-entry digit table (indexes 1, 2) while the block is idle.
// Operation:
//   The front queues up to two classified numbers. The back divides with a
//   single long-division unit that runs over the whole magnitude for each
//   digit, pushing digits onto a stack RAM; emission then reads each digit
//   off the stack and loads it into the output register, after a '-' for
//   a negative number.
// Reset and stall:
//   Reset empties the queue, idles the back, drops any pending character and
//   restores radix 10 with table "0123456789abcdef". A stalled receiver holds
//   the output register; the back waits, and the queue keeps taking input
//   until it is full.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_core
  import itrd_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [MAG_W-1:0]      number_value_i,
  input  logic [1:0]            opcode_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  last_char_o
);

  itrd_cfg_t cfg_q;
  itrd_job_t job;
  logic      job_valid;
  logic      job_pop;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix      <= RADIX_RST;
      cfg_q.chars_low  <= CHARS_LOW_RST;
      cfg_q.chars_high <= CHARS_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADIX:      cfg_q.radix      <= cfg_wdata_i[RADIX_W-1:0];
        CFG_CHARS_LOW:  cfg_q.chars_low  <= cfg_wdata_i;
        CFG_CHARS_HIGH: cfg_q.chars_high <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Front: classify and queue.
  itrd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .number_value_i (number_value_i),
    .opcode_i       (opcode_i),
    .job_valid_o    (job_valid),
    .job_o          (job),
    .job_pop_i      (job_pop)
  );

  // Back: divide, stack and emit.
  itrd_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== rtl/itrd_checker.sv =====
// ----------------------------------------------------------------------------
// itrd_checker
// Port-level checks of the integer to radix digits block, bound to the top.
// ----------------------------------------------------------------------------
module itrd_checker
  import itrd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CHAR_W-1:0] out_char_o,
  input logic              last_char_o
);

  // No character is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // The queue fills only through an accepted transaction.
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted transaction");

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_char_o) && $stable(last_char_o))
    else $error("stalled output changed");

  // A character leaves only through a completed transaction.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output valid dropped without a transaction");

endmodule

bind integer_to_radix_digits_core itrd_checker u_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_to_radix_digits_core. A built-in predictor
// turns every accepted number into its expected character transactions under
// the current radix and digit table. A monitor compares each output
// transaction with the oldest expected one. Directed cases cover the field
// extremes, every opcode, the most negative signed value and radix
// clamping. Random phases then change the settings and vary idle and stall
// on both sides, including a long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itrd_pkg::*;

  localparam int CLK_HALF       = 4;     // 8 ns period
  localparam int RESET_CYCLES   = 5;
  localparam int IDLE_PCT       = 33;    // chance of idling in any one cycle
  localparam int SETTLE_CYCLES  = 16;    // back is done once the last char is out
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // well above a 64-digit division
  localparam int REPORT_MAX     = 10;

  // The block gives this opcode no name; it behaves as unsigned 64-bit.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_t;

  // --------------------------------------------------------------------------
  // DUT signals: every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = CFG_RADIX;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [MAG_W-1:0]      number_value_i = '0;
  logic [1:0]            opcode_i       = OP_S32;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [CHAR_W-1:0]     out_char_o;
  logic                  last_char_o;

  integer_to_radix_digits_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .number_value_i(number_value_i),
    .opcode_i      (opcode_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .last_char_o   (last_char_o)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the settings, expected characters and shared controls
  // --------------------------------------------------------------------------
  logic [RADIX_W-1:0]    radix_reg      = RADIX_RST;
  logic [CFG_DATA_W-1:0] chars_low_reg  = CHARS_LOW_RST;
  logic [CFG_DATA_W-1:0] chars_high_reg = CHARS_HIGH_RST;

  char_t pending_chars[$];
  int    mismatches = 0;
  bit    idle_on    = 1'b1;  // random idling on both sides
  int    hold_left  = 0;     // receiver hold-off, counted down by the monitor

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  // Convert one accepted number into the characters it must produce. Divide
  // off digits least significant first, then read them back in reverse
  // through the 16-entry table. Stack overflow cannot happen at 64 digits.
  function automatic void predict_digits(input logic [MAG_W-1:0] value,
                                         input logic [1:0] op);
    logic [MAG_W-1:0]        mag;
    logic [31:0]             word;
    logic                    neg;
    logic [RADIX_W-1:0]      base;
    logic [DIGIT_W-1:0]      digits [MAX_DIGITS_DEF];
    logic [2*CFG_DATA_W-1:0] tbl;
    int                      n;
    word = value[31:0];
    neg  = 1'b0;
    mag  = value;  // unsigned 64-bit and the unused opcode
    if (op == OP_S32) begin
      // The most negative value wraps back to 2^31: its true magnitude.
      neg = word[31];
      if (neg) word = ~word + 32'd1;
      mag = {32'd0, word};
    end else if (op == OP_U32) begin
      mag = {32'd0, word};
    end
    // Clamp radix register values outside 2..16.
    base = radix_reg;
    if (base < MIN_RADIX) base = MIN_RADIX;
    if (base > MAX_RADIX) base = MAX_RADIX;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % base);
      mag       = mag / base;
      n++;
    end while (mag != 0 && n < MAX_DIGITS_DEF);
    tbl = {chars_high_reg, chars_low_reg};
    if (neg) pending_chars.push_back('{MINUS_CHAR, 1'b0});
    for (int i = n - 1; i >= 0; i--)
      pending_chars.push_back('{tbl[digits[i] * CHAR_W +: CHAR_W], i == 0});
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one number; leave valid high after acceptance so that a following
  // call can present the next transaction without a bubble.
  task automatic send_number(input logic [MAG_W-1:0] value, input logic [1:0] op);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    number_value_i <= value;
    opcode_i       <= op;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_digits(value, op);
  endtask

  // Drop valid, wait for every expected character, then let the back settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three registers back to back, only while the block is idle.
  task automatic load_settings(input logic [RADIX_W-1:0] radix,
                               input logic [CFG_DATA_W-1:0] chars_low,
                               input logic [CFG_DATA_W-1:0] chars_high);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_RADIX;
    cfg_wdata_i <= CFG_DATA_W'(radix);
    @(posedge clk_i);
    cfg_index_i <= CFG_CHARS_LOW;
    cfg_wdata_i <= chars_low;
    @(posedge clk_i);
    cfg_index_i <= CFG_CHARS_HIGH;
    cfg_wdata_i <= chars_high;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    radix_reg      = radix;
    chars_low_reg  = chars_low;
    chars_high_reg = chars_high;
  endtask

  task automatic load_random_settings();
    logic [RADIX_W-1:0] radix;
    // Mostly legal radixes; now and then any register value, clamped.
    if ($urandom_range(5) == 0) radix = RADIX_W'($urandom_range(31));
    else radix = RADIX_W'($urandom_range(16, 2));
    load_settings(radix, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // Mix of full-width values, short magnitudes and small negatives.
  function automatic logic [MAG_W-1:0] random_number();
    logic [MAG_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0:       v = v >> $urandom_range(MAG_W - 1);
      1:       v = ~(v >> $urandom_range(MAG_W - 1));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_number(random_number(), 2'($urandom_range(3)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset settings: decimal, "0123456789abcdef".
  task automatic test_reset_defaults();
    send_number(64'd0, OP_S32);
    send_number(64'd1, OP_S32);
    send_number(64'hFFFF_FFFF, OP_S32);                 // -1
    send_number(64'h7FFF_FFFF, OP_S32);                 // largest positive
    send_number(64'h8000_0000, OP_S32);                 // most negative
    send_number(64'hFFFF_FFFF_FFFF_FF85, OP_S32);       // -123, upper word ignored
    send_number(64'hDEAD_BEEF_0000_0005, OP_S32);       // upper word ignored
    send_number(64'hFFFF_FFFF, OP_U32);
    send_number(64'hA5A5_A5A5_0000_0000, OP_U32);       // low word zero
    send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_U64);
    send_number(64'hFEDC_BA98_7654_3210, OP_UNUSED);    // acts as unsigned 64-bit
  endtask

  // Radix 2 gives the longest strings; radix 16 with extreme table bytes.
  task automatic test_radix_extremes();
    load_settings(5'd2, 64'h4847_4645_4443_4241, 64'h5150_4F4E_4D4C_4B4A);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_U64);       // 64 digits
    send_number(64'h8000_0000, OP_S32);                 // minus and 2^31
    send_number(64'h8000_0000_0000_0000, OP_U64);
    load_settings(5'd16, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_U64);
    send_number(64'hFFFF_FFFF, OP_S32);
    send_number(64'h0123_4567_89AB_CDEF, OP_U64);
    send_number(64'h1234_5678_9ABC_DEF0, OP_UNUSED);
  endtask

  // Register values outside 2..16 clamp to the nearest legal radix.
  task automatic test_radix_clamp();
    load_settings(5'd0, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_number(64'd5, OP_U32);
    load_settings(5'd1, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_number(64'hFFFF_FFFA, OP_S32);
    load_settings(5'd31, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, OP_U64);
    load_settings(5'd17, CHARS_LOW_RST, CHARS_HIGH_RST);
    send_number(64'h1234_5678_9ABC_DEF0, OP_U64);
  endtask

  // Random numbers under a fresh random radix and table per phase.
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      load_random_settings();
      send_random(12);
    end
  endtask

  // Back-to-back transactions with neither side idling.
  task automatic test_full_rate();
    wait_idle();
    idle_on = 1'b0;
    send_random(16);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Hold the receiver off long enough for the queue to fill and stall input.
  task automatic test_backpressure();
    wait_idle();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 10; i++)
      send_number(64'($urandom_range(999)), 2'($urandom_range(3)));
    wait_idle();
  endtask

  // Pause the sender until every character has come out, then resume.
  task automatic test_sender_pause();
    send_random(4);
    wait_idle();
    send_random(4);
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Output monitor and receiver stall
  // --------------------------------------------------------------------------
  // Sample the handshake with pre-edge values, then pick the next stall.
  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        note_mismatch($sformatf("unexpected char %02h last %0b",
                                out_char_o, last_char_o));
      end else begin
        want = pending_chars.pop_front();
        if (out_char_o !== want.ch || last_char_o !== want.last)
          note_mismatch($sformatf("char exp %02h got %02h, last exp %0b got %0b",
                                  want.ch, out_char_o, want.last, last_char_o));
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Stop the run if nothing moves on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_radix_extremes();
    test_radix_clamp();
    test_random_settings();
    test_full_rate();
    test_backpressure();
    test_sender_pause();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
